// ===== rtl/rcsa_pkg.sv =====
// ---------------------------------------------------------------------------
// rcsa_pkg
// shared types and constants of the rc stick arming and setpoint mapper
// ---------------------------------------------------------------------------
package rcsa_pkg;

   // serial divider and root unit widths
   localparam int DIV_NW = 31;
   localparam int DIV_DW = 16;
   localparam int DIV_CW = 5;
   localparam int SQ_W   = 32;
   localparam int SQ_RW  = 16;
   localparam int SQ_CW  = 4;

   localparam logic [11:0] CENTRE_PULSE = 12'd1500;
   localparam logic [18:0] FULL_THR_Q8  = 19'd25600;

   localparam logic [1:0] OUT_UPDATED  = 2'd0;
   localparam logic [1:0] OUT_INVALID  = 2'd1;
   localparam logic [1:0] OUT_DISARMED = 2'd2;
   localparam logic [1:0] OUT_IDLE     = 2'd3;

   localparam logic [2:0] CSR_PULSE_MIN = 3'd0;
   localparam logic [2:0] CSR_PULSE_MAX = 3'd1;
   localparam logic [2:0] CSR_ARM_BAND  = 3'd2;
   localparam logic [2:0] CSR_MAX_TILT  = 3'd3;
   localparam logic [2:0] CSR_MAX_HDG   = 3'd4;
   localparam logic [2:0] CSR_IDLE_THR  = 3'd5;
   localparam logic [2:0] CSR_FULL_THR  = 3'd6;
   localparam logic [2:0] CSR_SLOTS     = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MAP_STORE,
      ST_SQ_R,
      ST_SQ_P,
      ST_SQ_CMP,
      ST_SQRT_WAIT,
      ST_SCALE_STORE,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/rcsa_div.sv =====
// ---------------------------------------------------------------------------
// rcsa_div
// bit-serial restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module rcsa_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rcsa_pkg::DIV_NW-1:0]  num,
   input  logic [rcsa_pkg::DIV_DW-1:0]  den,
   output logic                         done,
   output logic [rcsa_pkg::DIV_NW-1:0]  quo
);

   logic [rcsa_pkg::DIV_DW-1:0] den_ff;
   logic [rcsa_pkg::DIV_DW-1:0] rem_ff, rem_in;
   logic [rcsa_pkg::DIV_NW-1:0] q_ff, q_in;
   logic [rcsa_pkg::DIV_CW-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [rcsa_pkg::DIV_DW:0]   sh;
   logic                        fit;

   assign sh  = {rem_ff, q_ff[rcsa_pkg::DIV_NW-1]};
   assign fit = sh >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         q_in    = num;
         cnt_in  = rcsa_pkg::DIV_CW'(rcsa_pkg::DIV_NW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fit ? sh[rcsa_pkg::DIV_DW-1:0] - den_ff : sh[rcsa_pkg::DIV_DW-1:0];
         q_in   = {q_ff[rcsa_pkg::DIV_NW-2:0], fit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      if (start) den_ff <= den;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

// ===== rtl/rcsa_sqrt.sv =====
// ---------------------------------------------------------------------------
// rcsa_sqrt
// digit-serial floor square root, two radicand bits per cycle
// ---------------------------------------------------------------------------
module rcsa_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rcsa_pkg::SQ_W-1:0]   val,
   output logic                        done,
   output logic [rcsa_pkg::SQ_RW-1:0]  root
);

   logic [rcsa_pkg::SQ_W-1:0]  v_ff, v_in;
   logic [rcsa_pkg::SQ_RW+1:0] rem_ff, rem_in;
   logic [rcsa_pkg::SQ_RW-1:0] r_ff, r_in;
   logic [rcsa_pkg::SQ_CW-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [rcsa_pkg::SQ_RW+1:0] sh, trial;
   logic                       fit;

   assign sh    = {rem_ff[rcsa_pkg::SQ_RW-1:0], v_ff[rcsa_pkg::SQ_W-1 -: 2]};
   assign trial = {r_ff, 2'b01};
   assign fit   = sh >= trial;

   always_comb begin
      v_in    = v_ff;
      rem_in  = rem_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = val;
         rem_in  = '0;
         r_in    = '0;
         cnt_in  = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in   = {v_ff[rcsa_pkg::SQ_W-3:0], 2'b00};
         rem_in = fit ? sh - trial : sh;
         r_in   = {r_ff[rcsa_pkg::SQ_RW-2:0], fit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      rem_ff <= rem_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign root = r_ff;

endmodule

// ===== rtl/rc_stick_arming_and_setpoint_mapper.sv =====
// ---------------------------------------------------------------------------
// rc_stick_arming_and_setpoint_mapper
// rc stick arming, failsafe and 8.8 setpoint mapping per control tick
// ---------------------------------------------------------------------------
// usage
//  req channel: one item per control tick with four pulse widths (us)
//  rsp channel: one item per request with held setpoints, flags and outcome
//  csr channel: register writes, always ready; the user must write only
//  while the block is idle, which the block does not enforce; invalid,
//  disarm and idle ticks go from acceptance via the decide state to the
//  output state; an updated tick maps four channels through one serial
//  divider and, when the roll/pitch vector is too long, adds a 16-step
//  root and two more divides; throughput: one item at a time; req_stall
//  is high from acceptance until the result is moved into the output
//  register; a finished item waits in the output register while
//  rsp_stall is high, and the next request can already be taken meanwhile
//  reset: registers to their defaults, held pulses to 1500, unarmed
// ---------------------------------------------------------------------------
module rc_stick_arming_and_setpoint_mapper (
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [11:0]        req_throttle_pulse,
   input  logic [11:0]        req_roll_pulse,
   input  logic [11:0]        req_pitch_pulse,
   input  logic [11:0]        req_heading_pulse,
   // response
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_roll_cmd,
   output logic signed [15:0] rsp_pitch_cmd,
   output logic signed [16:0] rsp_heading_cmd,
   output logic [14:0]        rsp_throttle_cmd,
   output logic               rsp_is_armed,
   output logic               rsp_rc_failsafe,
   output logic               rsp_clear_imu_cal,
   output logic [1:0]         rsp_tick_outcome,
   // register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [11:0]        csr_wdata
);

   // configuration
   logic [11:0] pmin_ff, pmax_ff;
   logic [8:0]  band_ff;
   logic [6:0]  tilt_ff, idle_ff, full_ff;
   logic [7:0]  hmax_ff, slots_ff;

   // tick state
   rcsa_pkg::state_type state_ff, state_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [11:0] held_p_ff, held_p_in, held_h_ff, held_h_in;
   logic [11:0] thr_ff, thr_in, rol_ff, rol_in, pit_raw_ff, pit_raw_in;
   logic [11:0] hdg_raw_ff, hdg_raw_in, hdg_x_ff, hdg_x_in;
   logic        armed_ff, armed_in, fs_ff, fs_in, clr_ff, clr_in;
   logic [1:0]  outcome_ff, outcome_in;
   logic signed [16:0] sp_ff [4];
   logic signed [16:0] sp_in [4];
   logic [1:0]  k_ff, k_in;
   logic        scale_ff, scale_in;
   logic signed [31:0] prod_ff, prod_in, quo_ff, quo_in;
   logic        neg_ff, neg_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] root_ff, root_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in, rsp_load;
   logic signed [15:0] o_roll_ff, o_pitch_ff;
   logic signed [16:0] o_hdg_ff;
   logic [14:0] o_thr_ff;
   logic        o_armed_ff, o_fs_ff, o_clr_ff;
   logic [1:0]  o_out_ff;

   // sampling schedule and stick tests
   logic [7:0]  cnt_inc, cnt_nxt;
   logic [11:0] p_new, h_new;
   logic signed [14:0] lim_lo, lim_hi_m, lim_hi_p;
   logic signed [14:0] s_thr, s_rol, s_pit, s_hdg;
   logic        bad, do_arm, do_disarm;

   // mapping datapath
   logic signed [18:0] m_s, hm_s, x_sel, lo_sel, hi_sel, cl_lo, cl_hi;
   logic signed [18:0] mul_a, mul_b;
   logic signed [37:0] mul_p;
   logic signed [12:0] span;
   logic [11:0] span_abs;
   logic [31:0] prod_abs;
   logic [15:0] den;
   logic [30:0] num;
   logic signed [31:0] map_v;

   // serial units
   logic        div_start, div_done, sq_start, sq_done;
   logic [30:0] div_q;
   logic [15:0] sq_root;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pmin_ff  <= 12'd1000;
         pmax_ff  <= 12'd2000;
         band_ff  <= 9'd50;
         tilt_ff  <= 7'd30;
         hmax_ff  <= 8'd30;
         idle_ff  <= 7'd0;
         full_ff  <= 7'd100;
         slots_ff <= 8'd10;
      end else if (csr_valid) begin
         unique case (csr_index)
            rcsa_pkg::CSR_PULSE_MIN: pmin_ff  <= csr_wdata;
            rcsa_pkg::CSR_PULSE_MAX: pmax_ff  <= csr_wdata;
            rcsa_pkg::CSR_ARM_BAND:  band_ff  <= csr_wdata[8:0];
            rcsa_pkg::CSR_MAX_TILT:  tilt_ff  <= csr_wdata[6:0];
            rcsa_pkg::CSR_MAX_HDG:   hmax_ff  <= csr_wdata[7:0];
            rcsa_pkg::CSR_IDLE_THR:  idle_ff  <= csr_wdata[6:0];
            rcsa_pkg::CSR_FULL_THR:  full_ff  <= csr_wdata[6:0];
            rcsa_pkg::CSR_SLOTS:     slots_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // slot counter: pitch on count 1, heading half a round later
   assign cnt_inc = cnt_ff + 8'd1;
   assign cnt_nxt = (cnt_inc == slots_ff) ? 8'd0 : cnt_inc;
   assign p_new   = (cnt_inc == 8'd1) ? pit_raw_ff : held_p_ff;
   assign h_new   = (cnt_inc == {1'b0, slots_ff[7:1]} + 8'd1) ? hdg_raw_ff : held_h_ff;

   // stick thresholds, pulse_max - band may go negative
   assign lim_lo   = $signed({3'b0, pmin_ff}) + $signed({6'b0, band_ff});
   assign lim_hi_m = $signed({3'b0, pmax_ff}) - $signed({6'b0, band_ff});
   assign lim_hi_p = $signed({3'b0, pmax_ff}) + $signed({6'b0, band_ff});
   assign s_thr    = $signed({3'b0, thr_ff});
   assign s_rol    = $signed({3'b0, rol_ff});
   assign s_pit    = $signed({3'b0, p_new});
   assign s_hdg    = $signed({3'b0, h_new});

   assign bad       = (p_new == 12'd0) && (h_new == 12'd0);
   assign do_arm    = !armed_ff && (s_thr < lim_lo) && (s_hdg < lim_lo) &&
                      (s_pit < lim_lo) && (s_rol > lim_hi_m);
   assign do_disarm = armed_ff && (s_thr < lim_lo) && (s_pit < lim_hi_p) &&
                      (s_hdg > lim_hi_m) && (s_rol < lim_lo);

   // per channel ends: roll, pitch, heading, throttle
   assign m_s  = $signed({4'b0, tilt_ff, 8'b0});
   assign hm_s = $signed({3'b0, hmax_ff, 8'b0});

   always_comb begin
      unique case (k_ff)
         2'd0: begin
            x_sel = $signed({7'b0, rol_ff});
            lo_sel = -m_s;  hi_sel = m_s;  cl_lo = -m_s;  cl_hi = m_s;
         end
         2'd1: begin
            x_sel = $signed({7'b0, held_p_ff});
            lo_sel = -m_s;  hi_sel = m_s;  cl_lo = -m_s;  cl_hi = m_s;
         end
         2'd2: begin
            x_sel = $signed({7'b0, hdg_x_ff});
            lo_sel = -hm_s; hi_sel = hm_s; cl_lo = -hm_s; cl_hi = hm_s;
         end
         default: begin
            x_sel  = $signed({7'b0, thr_ff});
            lo_sel = $signed({4'b0, idle_ff, 8'b0});
            hi_sel = $signed({4'b0, full_ff, 8'b0});
            cl_lo  = '0;
            cl_hi  = $signed(rcsa_pkg::FULL_THR_Q8);
         end
      endcase
   end

   assign span     = $signed({1'b0, pmax_ff}) - $signed({1'b0, pmin_ff});
   assign span_abs = span[12] ? 12'(-span) : span[11:0];

   // one shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         rcsa_pkg::ST_MUL: begin
            if (scale_ff) begin
               mul_a = 19'(sp_ff[k_ff]);
               mul_b = m_s;
            end else begin
               mul_a = x_sel - $signed({7'b0, pmin_ff});
               mul_b = hi_sel - lo_sel;
            end
         end
         rcsa_pkg::ST_SQ_R:   begin mul_a = 19'(sp_ff[0]); mul_b = 19'(sp_ff[0]); end
         rcsa_pkg::ST_SQ_P:   begin mul_a = 19'(sp_ff[1]); mul_b = 19'(sp_ff[1]); end
         rcsa_pkg::ST_SQ_CMP: begin mul_a = m_s; mul_b = m_s; end
         default: ;
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // round to nearest, ties away from zero: (|n| + d/2) / d with sign
   assign prod_abs = prod_ff[31] ? 32'(-prod_ff) : prod_ff;
   assign den      = scale_ff ? root_ff : {4'b0, span_abs};
   assign num      = prod_abs[30:0] + {16'b0, den[15:1]};

   assign map_v = ((!scale_ff && span == '0) ? 32'sd0 : quo_ff) + 32'(lo_sel);

   rcsa_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (den),
      .done  (div_done),
      .quo   (div_q)
   );

   rcsa_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .val   (acc_ff),
      .done  (sq_done),
      .root  (sq_root)
   );

   // tick sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      held_p_in  = held_p_ff;
      held_h_in  = held_h_ff;
      thr_in     = thr_ff;
      rol_in     = rol_ff;
      pit_raw_in = pit_raw_ff;
      hdg_raw_in = hdg_raw_ff;
      hdg_x_in   = hdg_x_ff;
      armed_in   = armed_ff;
      fs_in      = fs_ff;
      clr_in     = clr_ff;
      outcome_in = outcome_ff;
      sp_in      = sp_ff;
      k_in       = k_ff;
      scale_in   = scale_ff;
      prod_in    = prod_ff;
      quo_in     = quo_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;
      root_in    = root_ff;
      div_start  = 1'b0;
      sq_start   = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         rcsa_pkg::ST_IDLE: begin
            if (req_valid) begin
               thr_in     = req_throttle_pulse;
               rol_in     = req_roll_pulse;
               pit_raw_in = req_pitch_pulse;
               hdg_raw_in = req_heading_pulse;
               state_in   = rcsa_pkg::ST_DECIDE;
            end
         end
         rcsa_pkg::ST_DECIDE: begin
            cnt_in    = cnt_nxt;
            held_p_in = p_new;
            held_h_in = h_new;
            hdg_x_in  = h_new;
            k_in      = 2'd0;
            scale_in  = 1'b0;
            clr_in    = 1'b0;
            priority if (bad) begin
               armed_in   = 1'b0;
               fs_in      = 1'b1;
               clr_in     = 1'b1;
               outcome_in = rcsa_pkg::OUT_INVALID;
               state_in   = rcsa_pkg::ST_OUT;
            end else if (do_arm) begin
               // arming centres heading for this tick
               armed_in   = 1'b1;
               fs_in      = 1'b0;
               hdg_x_in   = rcsa_pkg::CENTRE_PULSE;
               outcome_in = rcsa_pkg::OUT_UPDATED;
               state_in   = rcsa_pkg::ST_MUL;
            end else if (do_disarm) begin
               armed_in   = 1'b0;
               clr_in     = 1'b1;
               outcome_in = rcsa_pkg::OUT_DISARMED;
               state_in   = rcsa_pkg::ST_OUT;
            end else if (armed_ff) begin
               outcome_in = rcsa_pkg::OUT_UPDATED;
               state_in   = rcsa_pkg::ST_MUL;
            end else begin
               outcome_in = rcsa_pkg::OUT_IDLE;
               state_in   = rcsa_pkg::ST_OUT;
            end
         end
         rcsa_pkg::ST_MUL: begin
            prod_in  = mul_p[31:0];
            state_in = (!scale_ff && span == '0) ? rcsa_pkg::ST_MAP_STORE
                                                 : rcsa_pkg::ST_DIV_START;
         end
         rcsa_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            neg_in   = scale_ff ? prod_ff[31] : (prod_ff[31] ^ span[12]);
            state_in = rcsa_pkg::ST_DIV_WAIT;
         end
         rcsa_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               quo_in   = neg_ff ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
               state_in = scale_ff ? rcsa_pkg::ST_SCALE_STORE : rcsa_pkg::ST_MAP_STORE;
            end
         end
         rcsa_pkg::ST_MAP_STORE: begin
            priority if (map_v < 32'(cl_lo)) sp_in[k_ff] = 17'(cl_lo);
            else if (map_v > 32'(cl_hi))     sp_in[k_ff] = 17'(cl_hi);
            else                             sp_in[k_ff] = map_v[16:0];
            if (k_ff == 2'd3) begin
               state_in = rcsa_pkg::ST_SQ_R;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = rcsa_pkg::ST_MUL;
            end
         end
         rcsa_pkg::ST_SQ_R: begin
            acc_in   = mul_p[31:0];
            state_in = rcsa_pkg::ST_SQ_P;
         end
         rcsa_pkg::ST_SQ_P: begin
            acc_in   = acc_ff + mul_p[31:0];
            state_in = rcsa_pkg::ST_SQ_CMP;
         end
         rcsa_pkg::ST_SQ_CMP: begin
            // vector longer than the tilt limit gets rescaled
            if (acc_ff > mul_p[31:0]) begin
               sq_start = 1'b1;
               state_in = rcsa_pkg::ST_SQRT_WAIT;
            end else begin
               state_in = rcsa_pkg::ST_OUT;
            end
         end
         rcsa_pkg::ST_SQRT_WAIT: begin
            if (sq_done) begin
               root_in  = sq_root;
               k_in     = 2'd0;
               scale_in = 1'b1;
               state_in = rcsa_pkg::ST_MUL;
            end
         end
         rcsa_pkg::ST_SCALE_STORE: begin
            sp_in[k_ff] = quo_ff[16:0];
            if (k_ff == 2'd1) begin
               state_in = rcsa_pkg::ST_OUT;
            end else begin
               k_in     = 2'd1;
               state_in = rcsa_pkg::ST_MUL;
            end
         end
         rcsa_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = rcsa_pkg::ST_IDLE;
            end
         end
         default: state_in = rcsa_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcsa_pkg::ST_IDLE;
         cnt_ff       <= '0;
         held_p_ff    <= rcsa_pkg::CENTRE_PULSE;
         held_h_ff    <= rcsa_pkg::CENTRE_PULSE;
         armed_ff     <= 1'b0;
         fs_ff        <= 1'b0;
         clr_ff       <= 1'b0;
         outcome_ff   <= rcsa_pkg::OUT_IDLE;
         k_ff         <= '0;
         scale_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) sp_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         held_p_ff    <= held_p_in;
         held_h_ff    <= held_h_in;
         armed_ff     <= armed_in;
         fs_ff        <= fs_in;
         clr_ff       <= clr_in;
         outcome_ff   <= outcome_in;
         k_ff         <= k_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
         sp_ff        <= sp_in;
      end
      thr_ff     <= thr_in;
      rol_ff     <= rol_in;
      pit_raw_ff <= pit_raw_in;
      hdg_raw_ff <= hdg_raw_in;
      hdg_x_ff   <= hdg_x_in;
      prod_ff    <= prod_in;
      quo_ff     <= quo_in;
      neg_ff     <= neg_in;
      acc_ff     <= acc_in;
      root_ff    <= root_in;
      if (rsp_load) begin
         o_roll_ff  <= sp_ff[0][15:0];
         o_pitch_ff <= sp_ff[1][15:0];
         o_hdg_ff   <= sp_ff[2];
         o_thr_ff   <= sp_ff[3][14:0];
         o_armed_ff <= armed_ff;
         o_fs_ff    <= fs_ff;
         o_clr_ff   <= clr_ff;
         o_out_ff   <= outcome_ff;
      end
   end

   assign req_stall         = state_ff != rcsa_pkg::ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_roll_cmd      = o_roll_ff;
   assign rsp_pitch_cmd     = o_pitch_ff;
   assign rsp_heading_cmd   = o_hdg_ff;
   assign rsp_throttle_cmd  = o_thr_ff;
   assign rsp_is_armed      = o_armed_ff;
   assign rsp_rc_failsafe   = o_fs_ff;
   assign rsp_clear_imu_cal = o_clr_ff;
   assign rsp_tick_outcome  = o_out_ff;

endmodule
